// ===== hdl/thd_pkg.sv =====
// Package for the tag header decoder: field widths, flag byte layout,
// result type. No dependencies.
`default_nettype none
package thd_pkg;

   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned TypeWidth  = 2;
   localparam int unsigned WordWidth  = 32;
   localparam int unsigned CountWidth = 3;

   // flag byte layout
   localparam int unsigned TypeLsb    = 4;
   localparam int unsigned SeqLenLsb  = 2;
   localparam int unsigned TimeLenLsb = 0;
   localparam int unsigned LenWidth   = 2;

   typedef struct packed {
      logic [TypeWidth-1:0] packet_type;
      logic [WordWidth-1:0] sequence_number;
      logic [WordWidth-1:0] sent_time;
   } thd_result_type;

   // byte count of a length code: code 0..3 means 1..4 bytes
   function automatic logic [CountWidth-1:0] len_count(input logic [LenWidth-1:0] code);
      len_count = {{(CountWidth-LenWidth){1'b0}}, code} + CountWidth'(1);
   endfunction

endpackage : thd_pkg
`default_nettype wire

// ===== hdl/thd_stream_if.sv =====
// Valid/ready stream interfaces for the tag header decoder channels.
// Depends on thd_pkg.
`default_nettype none
interface thd_req_if;
   logic                              valid;
   logic                              ready;
   logic [thd_pkg::ByteWidth-1:0]     byte_in;

   modport source (output valid, output byte_in, input ready);
   modport sink   (input valid, input byte_in, output ready);
endinterface : thd_req_if

interface thd_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [thd_pkg::TypeWidth-1:0]     packet_type;
   logic [thd_pkg::WordWidth-1:0]     sequence_number;
   logic [thd_pkg::WordWidth-1:0]     sent_time;

   modport source (output valid, output packet_type, output sequence_number,
                   output sent_time, input ready);
   modport sink   (input valid, input packet_type, input sequence_number,
                   input sent_time, output ready);
endinterface : thd_rsp_if
`default_nettype wire

// ===== hdl/thd_parse.sv =====
// Tag parser: phase tracking, byte counting and field accumulation.
// Depends on thd_pkg.
`default_nettype none
module thd_parse (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          fire,
   input  wire logic [thd_pkg::ByteWidth-1:0] byte_in,
   output logic                               res_valid,
   output thd_pkg::thd_result_type            res,
   output logic                               last_pending
);

   typedef enum logic [1:0] {
      PH_FLAG = 2'd0,
      PH_SEQ  = 2'd1,
      PH_TIME = 2'd2
   } phase_type;

   localparam int unsigned BW = thd_pkg::ByteWidth;
   localparam int unsigned WW = thd_pkg::WordWidth;
   localparam int unsigned CW = thd_pkg::CountWidth;

   phase_type                        phase_ff, phase_in;
   logic [CW-1:0]                    bytes_left_ff, bytes_left_in;
   logic [CW-1:0]                    time_bytes_ff, time_bytes_in;
   logic [thd_pkg::TypeWidth-1:0]    type_hold_ff, type_hold_in;
   logic [WW-1:0]                    seq_accum_ff, seq_accum_in;
   logic [WW-1:0]                    time_accum_ff, time_accum_in;
   logic [WW-1:0]                    seq_shift, time_shift;
   logic                             field_last;

   assign seq_shift  = {seq_accum_ff[WW-BW-1:0], byte_in};
   assign time_shift = {time_accum_ff[WW-BW-1:0], byte_in};
   // a zero count is taken as the last byte too
   assign field_last = (bytes_left_ff <= CW'(1));

   always_comb begin
      phase_in      = phase_ff;
      bytes_left_in = bytes_left_ff;
      time_bytes_in = time_bytes_ff;
      type_hold_in  = type_hold_ff;
      seq_accum_in  = seq_accum_ff;
      time_accum_in = time_accum_ff;
      res_valid     = 1'b0;
      if (fire) begin
         unique case (phase_ff)
            PH_SEQ: begin
               seq_accum_in  = seq_shift;
               bytes_left_in = field_last ? time_bytes_ff : bytes_left_ff - CW'(1);
               if (field_last) phase_in = PH_TIME;
            end
            PH_TIME: begin
               time_accum_in = time_shift;
               bytes_left_in = field_last ? '0 : bytes_left_ff - CW'(1);
               if (field_last) begin
                  phase_in  = PH_FLAG;
                  res_valid = 1'b1;
               end
            end
            default: begin
               type_hold_in  = byte_in[thd_pkg::TypeLsb +: thd_pkg::TypeWidth];
               bytes_left_in = thd_pkg::len_count(
                                  byte_in[thd_pkg::SeqLenLsb +: thd_pkg::LenWidth]);
               time_bytes_in = thd_pkg::len_count(
                                  byte_in[thd_pkg::TimeLenLsb +: thd_pkg::LenWidth]);
               seq_accum_in  = '0;
               time_accum_in = '0;
               phase_in      = PH_SEQ;
            end
         endcase
      end
   end

   assign res.packet_type     = type_hold_ff;
   assign res.sequence_number = seq_accum_ff;
   assign res.sent_time       = time_shift;

   // next beat would close a tag and needs room in the result register
   assign last_pending = (phase_ff == PH_TIME) && field_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_FLAG;
         bytes_left_ff <= '0;
         time_bytes_ff <= '0;
         type_hold_ff  <= '0;
         seq_accum_ff  <= '0;
         time_accum_ff <= '0;
      end else begin
         phase_ff      <= phase_in;
         bytes_left_ff <= bytes_left_in;
         time_bytes_ff <= time_bytes_in;
         type_hold_ff  <= type_hold_in;
         seq_accum_ff  <= seq_accum_in;
         time_accum_ff <= time_accum_in;
      end
   end

`ifndef SYNTH
   a_flag_to_seq: assert property (@(posedge clock) disable iff (reset)
      fire && (phase_ff == PH_FLAG) |=> (phase_ff == PH_SEQ))
      else $error("flag beat did not start sequence phase");

   a_result_only_on_time: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> fire && (phase_ff == PH_TIME) && field_last)
      else $error("result raised outside the last timestamp beat");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SEQ) || (phase_ff == PH_TIME) |->
         (bytes_left_ff >= CW'(1)) && (bytes_left_ff <= CW'(4)))
      else $error("byte count out of range inside a field");
`endif

endmodule : thd_parse
`default_nettype wire

// ===== hdl/thd_out_reg.sv =====
// Result register between the parser and the result channel.
// Depends on thd_pkg.
`default_nettype none
module thd_out_reg (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    load,
   input  wire thd_pkg::thd_result_type load_data,
   input  wire logic                    rsp_ready,
   output logic                         rsp_valid,
   output thd_pkg::thd_result_type      rsp_data
);

   logic                    valid_ff, valid_in;
   thd_pkg::thd_result_type data_ff;

   assign valid_in  = load || (valid_ff && !rsp_ready);
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

`ifndef SYNTH
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> !valid_ff || rsp_ready)
      else $error("result register overwritten before it was taken");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> valid_ff)
      else $error("loaded result not presented");

   a_drain_clears: assert property (@(posedge clock) disable iff (reset)
      valid_ff && rsp_ready && !load |=> !valid_ff)
      else $error("taken result still presented");
`endif

endmodule : thd_out_reg
`default_nettype wire

// ===== hdl/tag_header_decoder.sv =====
// Tag header decoder: one tag byte per beat in, one result per tag out.
// The result is registered: it appears in the cycle after the last timestamp byte is taken.
// Throughput: one byte per cycle, except while the input is stalled as below.
// The input stalls only when a tag's closing byte arrives while the result
// register still holds an untaken result.
// Synchronous active-high reset returns the parser to expecting a flag byte.
`default_nettype none
module tag_header_decoder (
   input  wire logic  clock,
   input  wire logic  reset,
   thd_req_if.sink    req_bus,
   thd_rsp_if.source  rsp_bus
);

   logic                    fire;
   logic                    res_valid;
   logic                    last_pending;
   logic                    out_valid;
   thd_pkg::thd_result_type res;
   thd_pkg::thd_result_type out_data;

   assign req_bus.ready = !last_pending || !out_valid || rsp_bus.ready;
   assign fire          = req_bus.valid && req_bus.ready;

   thd_parse u_parse (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .byte_in      (req_bus.byte_in),
      .res_valid    (res_valid),
      .res          (res),
      .last_pending (last_pending)
   );

   thd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (res_valid),
      .load_data (res),
      .rsp_ready (rsp_bus.ready),
      .rsp_valid (out_valid),
      .rsp_data  (out_data)
   );

   assign rsp_bus.valid           = out_valid;
   assign rsp_bus.packet_type     = out_data.packet_type;
   assign rsp_bus.sequence_number = out_data.sequence_number;
   assign rsp_bus.sent_time       = out_data.sent_time;

endmodule : tag_header_decoder
`default_nettype wire
